// ===== rtl/dmwbc_pkg.sv =====
// shared types and constants for the direct-mapped write-back cache
// used by dmwbc_ctrl, dmwbc_datapath and direct_mapped_write_back_cache
`default_nettype none

package dmwbc_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 32;
    localparam int COST_W     = 10;
    localparam int ACOST_W    = 12;
    localparam int CFG_IDX_W  = 2;

    localparam int MEM_BYTES  = 65536;
    localparam int LINE_BYTES = 16;
    localparam int NUM_LINES  = 64;
    localparam int WORD_BYTES = 4;

    localparam int LINE_WORDS = LINE_BYTES / WORD_BYTES;
    localparam int BYTE_OFF_W = $clog2(WORD_BYTES);
    localparam int WOFF_W     = $clog2(LINE_WORDS);
    localparam int LOFF_W     = $clog2(LINE_BYTES);
    localparam int IDX_W      = $clog2(NUM_LINES);
    localparam int MEM_ROWS   = MEM_BYTES / LINE_BYTES;
    localparam int ROW_W      = $clog2(MEM_ROWS);
    localparam int TAG_W      = ROW_W - IDX_W;

    // operation codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_READ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_WRITE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_READ  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_WRITE = 2'd3;

    localparam logic [COST_W-1:0] DRAM_READ_RST   = 10'd100;
    localparam logic [COST_W-1:0] DRAM_WRITE_RST  = 10'd50;
    localparam logic [COST_W-1:0] CACHE_READ_RST  = 10'd1;
    localparam logic [COST_W-1:0] CACHE_WRITE_RST = 10'd1;

    typedef logic [LINE_WORDS-1:0][DATA_W-1:0] line_t;

    typedef struct packed {
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } tag_entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic clear_we;
        logic accept;
        logic look;
        logic resp_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/dmwbc_ctrl.sv =====
// controller state machine: memory clear after reset, accept, lookup, response
// depends on dmwbc_pkg
`default_nettype none

module dmwbc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire dmwbc_pkg::dp_status_t status,
    output dmwbc_pkg::ctrl_cmd_t       ctl,
    output dmwbc_pkg::state_t          ctrl_state
);

    dmwbc_pkg::state_t state_reg;
    dmwbc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmwbc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmwbc_pkg::ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = dmwbc_pkg::ST_IDLE;
                end
            end
            dmwbc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dmwbc_pkg::ST_LOOK;
                end
            end
            dmwbc_pkg::ST_LOOK:
            begin
                state_next = dmwbc_pkg::ST_RESP;
            end
            dmwbc_pkg::ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = dmwbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmwbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        ctl.clear_we  = 1'b0;
        ctl.accept    = 1'b0;
        ctl.look      = 1'b0;
        ctl.resp_load = 1'b0;
        case (state_reg)
            dmwbc_pkg::ST_CLEAR:
            begin
                ctl.clear_we = 1'b1;
            end
            dmwbc_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                ctl.accept = in_valid;
            end
            dmwbc_pkg::ST_LOOK:
            begin
                ctl.look = 1'b1;
            end
            dmwbc_pkg::ST_RESP:
            begin
                ctl.resp_load = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign ctrl_state = state_reg;

endmodule

`default_nettype wire

// ===== rtl/dmwbc_datapath.sv =====
// datapath: tag and line arrays, main memory, cost registers, result register
// depends on dmwbc_pkg; driven by dmwbc_ctrl
`default_nettype none

module dmwbc_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire dmwbc_pkg::ctrl_cmd_t                   ctl,
    output dmwbc_pkg::dp_status_t                       status,
    input  wire logic                                   cmd,
    input  wire logic [dmwbc_pkg::ADDR_W-1:0]           address,
    input  wire logic [dmwbc_pkg::DATA_W-1:0]           write_data,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [dmwbc_pkg::DATA_W-1:0]                read_data,
    output logic                                        hit,
    output logic [dmwbc_pkg::ACOST_W-1:0]               access_cost,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [dmwbc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [dmwbc_pkg::COST_W-1:0]           cfg_data
);

    // storage
    dmwbc_pkg::tag_entry_t tag_mem  [dmwbc_pkg::NUM_LINES];
    dmwbc_pkg::line_t      line_mem [dmwbc_pkg::NUM_LINES];
    dmwbc_pkg::line_t      main_mem [dmwbc_pkg::MEM_ROWS];
    logic [dmwbc_pkg::NUM_LINES-1:0] valid_reg;

    // registered array reads
    dmwbc_pkg::tag_entry_t tag_q_reg;
    dmwbc_pkg::line_t      line_q_reg;
    dmwbc_pkg::line_t      mem_q_reg;

    // captured request
    logic                          req_cmd_reg;
    logic [dmwbc_pkg::ROW_W-1:0]   req_row_reg;
    logic [dmwbc_pkg::WOFF_W-1:0]  req_woff_reg;
    logic [dmwbc_pkg::DATA_W-1:0]  req_wdata_reg;

    logic [dmwbc_pkg::COST_W-1:0]  dram_read_cost_reg;
    logic [dmwbc_pkg::COST_W-1:0]  dram_write_cost_reg;
    logic [dmwbc_pkg::COST_W-1:0]  cache_read_cost_reg;
    logic [dmwbc_pkg::COST_W-1:0]  cache_write_cost_reg;

    logic [dmwbc_pkg::ROW_W-1:0]   clear_cnt_reg;

    logic [dmwbc_pkg::DATA_W-1:0]  res_rdata_reg;
    logic                          res_hit_reg;
    logic [dmwbc_pkg::ACOST_W-1:0] res_cost_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [dmwbc_pkg::DATA_W-1:0]  read_data_reg;
    logic                          hit_reg;
    logic [dmwbc_pkg::ACOST_W-1:0] access_cost_reg;

    // lookup logic
    logic [dmwbc_pkg::IDX_W-1:0]   in_idx;
    logic [dmwbc_pkg::ROW_W-1:0]   in_row;
    logic [dmwbc_pkg::IDX_W-1:0]   req_idx;
    logic [dmwbc_pkg::TAG_W-1:0]   req_tag;
    logic                          is_write;
    logic                          is_hit;
    logic                          victim_wb;
    dmwbc_pkg::line_t              base_line;
    dmwbc_pkg::line_t              new_line;
    dmwbc_pkg::tag_entry_t         new_entry;
    logic [dmwbc_pkg::DATA_W-1:0]  look_rdata;
    logic [dmwbc_pkg::ACOST_W-1:0] look_cost;
    logic [dmwbc_pkg::ACOST_W-1:0] dram_part;

    logic                          mem_we;
    logic [dmwbc_pkg::ROW_W-1:0]   mem_waddr;
    dmwbc_pkg::line_t              mem_wdata;

    assign in_idx  = address[dmwbc_pkg::LOFF_W +: dmwbc_pkg::IDX_W];
    assign in_row  = address[dmwbc_pkg::LOFF_W +: dmwbc_pkg::ROW_W];
    assign req_idx = req_row_reg[dmwbc_pkg::IDX_W-1:0];
    assign req_tag = req_row_reg[dmwbc_pkg::ROW_W-1:dmwbc_pkg::IDX_W];

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            req_cmd_reg   <= cmd;
            req_row_reg   <= in_row;
            req_woff_reg  <= address[dmwbc_pkg::LOFF_W-1:dmwbc_pkg::BYTE_OFF_W];
            req_wdata_reg <= write_data;
        end
    end

    always_comb
    begin
        is_write  = (req_cmd_reg == dmwbc_pkg::CMD_WRITE);
        is_hit    = valid_reg[req_idx] && (tag_q_reg.tag == req_tag);
        victim_wb = valid_reg[req_idx] && tag_q_reg.dirty && !is_hit;
        base_line = is_hit ? line_q_reg : mem_q_reg;
        new_line  = base_line;
        if (is_write)
        begin
            new_line[req_woff_reg] = req_wdata_reg;
        end
        look_rdata      = is_write ? '0 : base_line[req_woff_reg];
        new_entry.tag   = req_tag;
        new_entry.dirty = is_write || (is_hit && tag_q_reg.dirty);

        dram_part = '0;
        if (!is_hit)
        begin
            dram_part = dmwbc_pkg::ACOST_W'(dram_read_cost_reg);
        end
        if (victim_wb)
        begin
            dram_part = dram_part + dmwbc_pkg::ACOST_W'(dram_write_cost_reg);
        end
        look_cost = dram_part + (is_write ? dmwbc_pkg::ACOST_W'(cache_write_cost_reg)
                                          : dmwbc_pkg::ACOST_W'(cache_read_cost_reg));
    end

    // cache arrays
    always_ff @(posedge clk)
    begin
        if (ctl.look)
        begin
            tag_mem[req_idx]  <= new_entry;
            line_mem[req_idx] <= new_line;
        end
        if (ctl.accept)
        begin
            tag_q_reg  <= tag_mem[in_idx];
            line_q_reg <= line_mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.look)
        begin
            valid_reg[req_idx] <= 1'b1;
        end
    end

    // main memory: clearing pass after reset, victim writeback on a dirty miss
    always_comb
    begin
        mem_we    = ctl.clear_we || (ctl.look && victim_wb);
        mem_waddr = ctl.clear_we ? clear_cnt_reg : {tag_q_reg.tag, req_idx};
        mem_wdata = ctl.clear_we ? '0 : line_q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            main_mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.accept)
        begin
            mem_q_reg <= main_mem[in_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (ctl.clear_we)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    assign status.clear_done = (clear_cnt_reg == dmwbc_pkg::ROW_W'(dmwbc_pkg::MEM_ROWS - 1));

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dram_read_cost_reg   <= dmwbc_pkg::DRAM_READ_RST;
            dram_write_cost_reg  <= dmwbc_pkg::DRAM_WRITE_RST;
            cache_read_cost_reg  <= dmwbc_pkg::CACHE_READ_RST;
            cache_write_cost_reg <= dmwbc_pkg::CACHE_WRITE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dmwbc_pkg::CFG_DRAM_READ:   dram_read_cost_reg   <= cfg_data;
                dmwbc_pkg::CFG_DRAM_WRITE:  dram_write_cost_reg  <= cfg_data;
                dmwbc_pkg::CFG_CACHE_READ:  cache_read_cost_reg  <= cfg_data;
                dmwbc_pkg::CFG_CACHE_WRITE: cache_write_cost_reg <= cfg_data;
                default:
                begin
                    dram_read_cost_reg <= dram_read_cost_reg;
                end
            endcase
        end
    end

    // result and output register
    always_ff @(posedge clk)
    begin
        if (ctl.look)
        begin
            res_rdata_reg <= look_rdata;
            res_hit_reg   <= is_hit;
            res_cost_reg  <= look_cost;
        end
        if (ctl.resp_load)
        begin
            read_data_reg   <= res_rdata_reg;
            hit_reg         <= res_hit_reg;
            access_cost_reg <= res_cost_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.resp_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign hit         = hit_reg;
    assign access_cost = access_cost_reg;

endmodule

`default_nettype wire

// ===== rtl/direct_mapped_write_back_cache.sv =====
// direct-mapped write-allocate write-back cache with its own main memory
// steps: accept, lookup/update, then the result moves into the output register once that is free
// one transaction at a time: a new request is accepted only after the last result enters the output register
// misses and dirty writebacks take the same states as hits: memory rows are one full line wide
// reset: main memory is zeroed by a clearing pass, in_stall stays high meanwhile
// depends on dmwbc_pkg, dmwbc_ctrl, dmwbc_datapath
`default_nettype none

module direct_mapped_write_back_cache (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               cmd,
    input  wire logic [dmwbc_pkg::ADDR_W-1:0]       address,
    input  wire logic [dmwbc_pkg::DATA_W-1:0]       write_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [dmwbc_pkg::DATA_W-1:0]            read_data,
    output logic                                    hit,
    output logic [dmwbc_pkg::ACOST_W-1:0]           access_cost,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dmwbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dmwbc_pkg::COST_W-1:0]       cfg_data
);

    dmwbc_pkg::ctrl_cmd_t  ctl;
    dmwbc_pkg::dp_status_t status;
    dmwbc_pkg::state_t     ctrl_state;

    dmwbc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .status     (status),
        .ctl        (ctl),
        .ctrl_state (ctrl_state)
    );

    dmwbc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status      (status),
        .cmd         (cmd),
        .address     (address),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .hit         (hit),
        .access_cost (access_cost),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

`ifndef NO_ASSERTIONS
    // one transaction in flight: no second accept right after the first
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted back to back");

    // nothing may be accepted while main memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_state == dmwbc_pkg::ST_CLEAR) |-> in_stall)
        else $error("input accepted during memory clear");

    // a hit never carries a main memory cost
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |->
        (access_cost[dmwbc_pkg::ACOST_W-1:dmwbc_pkg::COST_W] == '0))
        else $error("hit reports a memory cost");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for direct_mapped_write_back_cache: directed table, then random phases
// keeps its own cache and main memory model; depends on dmwbc_pkg and the cache rtl

module testbench;
    import dmwbc_pkg::*;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int NUM_DIRECTED = 20;
    localparam int MEM_WORDS    = MEM_BYTES / WORD_BYTES;

    typedef struct packed {
        logic [DATA_W-1:0]  rd;
        logic               hit;
        logic [ACOST_W-1:0] cost;
    } access_result_t;

    typedef struct packed {
        logic               op;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  wdata;
        logic               typed;
        access_result_t     result;
    } stim_row_t;

    // reset costs: dram read 100, dram write 50, cache read 1, cache write 1
    localparam stim_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
        '{CMD_READ,  16'h0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 12'd101}},
        '{CMD_READ,  16'h0004, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 12'd1}},
        '{CMD_WRITE, 16'h0008, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 12'd1}},
        '{CMD_READ,  16'h000B, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 12'd1}},
        '{CMD_WRITE, 16'h0400, 32'hA5A5_5A5A, 1'b1, '{32'h0000_0000, 1'b0, 12'd151}},
        '{CMD_READ,  16'h0008, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, 12'd151}},
        '{CMD_READ,  16'h0400, 32'h0000_0000, 1'b1, '{32'hA5A5_5A5A, 1'b0, 12'd101}},
        '{CMD_WRITE, 16'hFFFC, 32'h8000_0001, 1'b1, '{32'h0000_0000, 1'b0, 12'd101}},
        '{CMD_READ,  16'hFFFF, 32'h0000_0000, 1'b1, '{32'h8000_0001, 1'b1, 12'd1}},
        '{CMD_WRITE, 16'hFFF0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 12'd1}},
        '{CMD_READ,  16'h03FC, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 12'd151}},
        '{CMD_READ,  16'hFFFC, 32'h0000_0000, 1'b1, '{32'h8000_0001, 1'b0, 12'd101}},
        '{CMD_WRITE, 16'h1234, 32'h1234_5678, 1'b0, '0},
        '{CMD_READ,  16'h1236, 32'h0000_0000, 1'b0, '0},
        '{CMD_WRITE, 16'h5554, 32'h5555_5555, 1'b0, '0},
        '{CMD_WRITE, 16'hAAA8, 32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_READ,  16'h5557, 32'h0000_0000, 1'b0, '0},
        '{CMD_READ,  16'hAAAB, 32'h0000_0000, 1'b0, '0},
        // same index as 0x1234 with another tag: dirty victim goes back to memory
        '{CMD_WRITE, 16'h1634, 32'hDEAD_BEEF, 1'b0, '0},
        '{CMD_READ,  16'h1234, 32'h0000_0000, 1'b0, '0}
    };

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic                 cmd        = CMD_READ;
    logic [ADDR_W-1:0]    address    = '0;
    logic [DATA_W-1:0]    write_data = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [DATA_W-1:0]    read_data;
    logic                 hit;
    logic [ACOST_W-1:0]   access_cost;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_DRAM_READ;
    logic [COST_W-1:0]    cfg_data   = '0;

    direct_mapped_write_back_cache dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .address     (address),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .hit         (hit),
        .access_cost (access_cost),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // cache and memory mirror
    logic [COST_W-1:0] cost_dram_read   = DRAM_READ_RST;
    logic [COST_W-1:0] cost_dram_write  = DRAM_WRITE_RST;
    logic [COST_W-1:0] cost_cache_read  = CACHE_READ_RST;
    logic [COST_W-1:0] cost_cache_write = CACHE_WRITE_RST;
    logic              line_ok    [NUM_LINES]  = '{default: 1'b0};
    logic              line_dirty [NUM_LINES]  = '{default: 1'b0};
    logic [TAG_W-1:0]  line_tag   [NUM_LINES]  = '{default: '0};
    logic [DATA_W-1:0] line_data  [NUM_LINES*LINE_WORDS] = '{default: '0};
    logic [DATA_W-1:0] dram       [MEM_WORDS]  = '{default: '0};

    access_result_t    pending_results [$];
    access_result_t    oldest_result;
    int                mismatches    = 0;
    int                hit_count     = 0;
    int                miss_count    = 0;
    int                writebacks    = 0;
    int                cost_settings = 1;
    int                stall_left    = 0;
    bit                rx_calm       = 1'b0;
    logic [TAG_W-1:0]  hot_tags [4];
    logic [IDX_W-1:0]  hot_base;

    function automatic access_result_t cache_access(input logic op,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] wdata);
        access_result_t    res;
        logic [TAG_W-1:0]  tag;
        logic [IDX_W-1:0]  idx;
        logic [WOFF_W-1:0] woff;
        res  = '0;
        tag  = addr[ADDR_W-1 -: TAG_W];
        idx  = addr[LOFF_W +: IDX_W];
        woff = addr[BYTE_OFF_W +: WOFF_W];
        res.hit = line_ok[idx] && (line_tag[idx] == tag);
        if (!res.hit)
        begin
            res.cost += ACOST_W'(cost_dram_read);
            // victim and new block share the index but not the tag, so they never overlap
            if (line_ok[idx] && line_dirty[idx])
            begin
                for (int w = 0; w < LINE_WORDS; w++)
                    dram[{line_tag[idx], idx, WOFF_W'(w)}] = line_data[{idx, WOFF_W'(w)}];
                res.cost += ACOST_W'(cost_dram_write);
                writebacks++;
            end
            for (int w = 0; w < LINE_WORDS; w++)
                line_data[{idx, WOFF_W'(w)}] = dram[{tag, idx, WOFF_W'(w)}];
            line_ok[idx]    = 1'b1;
            line_tag[idx]   = tag;
            line_dirty[idx] = 1'b0;
            miss_count++;
        end
        else
            hit_count++;
        if (op == CMD_READ)
        begin
            res.rd = line_data[{idx, woff}];
            res.cost += ACOST_W'(cost_cache_read);
        end
        else
        begin
            line_data[{idx, woff}] = wdata;
            line_dirty[idx] = 1'b1;
            res.cost += ACOST_W'(cost_cache_write);
        end
        return res;
    endfunction

    // mostly back to back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // most addresses fall on a few tags over a narrow index window to force conflicts
    function automatic stim_row_t random_row();
        stim_row_t row;
        row = '0;
        row.op = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        if ($urandom_range(0, 9) < 7)
            row.addr = {hot_tags[$urandom_range(0, 3)],
                        IDX_W'(hot_base + $urandom_range(0, 7)), LOFF_W'($urandom)};
        else
            row.addr = ADDR_W'($urandom);
        row.wdata = $urandom;
        return row;
    endfunction

    // called at a falling edge, returns at the falling edge after the request is accepted
    task automatic send_access(input stim_row_t row, input bit idle);
        access_result_t predicted;
        int gap;
        gap = idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= row.op;
        address    <= row.addr;
        write_data <= row.wdata;
        do @(posedge clk); while (in_stall);
        predicted = cache_access(row.op, row.addr, row.wdata);
        pending_results.push_back(row.typed ? row.result : predicted);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cost_reg(input logic [CFG_IDX_W-1:0] index,
                                  input logic [COST_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_DRAM_READ:   cost_dram_read   = value;
            CFG_DRAM_WRITE:  cost_dram_write  = value;
            CFG_CACHE_READ:  cost_cache_read  = value;
            CFG_CACHE_WRITE: cost_cache_write = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_costs(input logic [COST_W-1:0] dram_rd, input logic [COST_W-1:0] dram_wr,
                               input logic [COST_W-1:0] cache_rd, input logic [COST_W-1:0] cache_wr);
        drain();
        write_cost_reg(CFG_DRAM_READ, dram_rd);
        write_cost_reg(CFG_DRAM_WRITE, dram_wr);
        write_cost_reg(CFG_CACHE_READ, cache_rd);
        write_cost_reg(CFG_CACHE_WRITE, cache_wr);
        cfg_valid <= 1'b0;
        cost_settings++;
    endtask

    // receiver back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!rx_calm)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no access outstanding");
                mismatches++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (read_data !== oldest_result.rd)
                begin
                    $error("read_data: expected %h, got %h", oldest_result.rd, read_data);
                    mismatches++;
                end
                if (hit !== oldest_result.hit)
                begin
                    $error("hit: expected %b, got %b", oldest_result.hit, hit);
                    mismatches++;
                end
                if (access_cost !== oldest_result.cost)
                begin
                    $error("access_cost: expected %0d, got %0d", oldest_result.cost, access_cost);
                    mismatches++;
                end
            end
        end
    end

    // the reset clearing pass fits well inside the limit
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int  phase;
        int  i;
        bit  calm;
        calm = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++)
            send_access(DIRECTED[i], 1'b1);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: apply_costs('0, '0, '0, '0);
                1: apply_costs('1, '1, '1, '1);
                2: apply_costs('1, '0, '1, '0);
                3: apply_costs('0, '1, '0, '1);
                default: apply_costs(COST_W'($urandom_range(0, 1023)),
                                     COST_W'($urandom_range(0, 1023)),
                                     COST_W'($urandom_range(0, 1023)),
                                     COST_W'($urandom_range(0, 1023)));
            endcase
            for (i = 0; i < 4; i++)
                hot_tags[i] = TAG_W'($urandom);
            hot_base = IDX_W'($urandom);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // occasional stretches with no gaps on one side or the other
                if (i % 50 == 0)
                begin
                    calm    = ($urandom_range(0, 3) == 0);
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                send_access(random_row(), !calm);
            end
        end
        drain();

        $display("covered %0d accesses: %0d hits, %0d misses, %0d dirty writebacks",
                 hit_count + miss_count, hit_count, miss_count, writebacks);
        $display("over %0d cost settings, zero and full-scale latencies included",
                 cost_settings);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
